@@ rtl/core/lfu_pkg.sv @@
// Shared types and constants for the LFU cache lookup/insert block.
// No dependencies; every other file in rtl/core except lfu_ram imports this package.
`default_nettype none

package lfu_pkg;

  localparam int DefEntries = 16;

  localparam int KeyW   = 32;
  localparam int DataW  = 32;
  localparam int CountW = 32;
  localparam int StampW = 48;
  localparam int CapW   = 5;
  localparam int WordW  = KeyW + DataW + CountW + StampW;

  localparam logic [CapW-1:0]  CapReset  = 5'd16;
  localparam logic [DataW-1:0] MissValue = {DataW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] CountNew = {{(CountW-1){1'b0}}, 1'b1};

  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCommit
  } lfu_state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;   // capture request, clear scan results
    logic scan;    // walk the occupied entries
    logic commit;  // write back, load result register
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // every occupied entry has been read; the compare of the last may still be under way
    logic out_free;   // result register can take a new result this cycle
  } lfu_status_t;

endpackage

`default_nettype wire

@@ rtl/core/lfu_req_if.sv @@
// Request channel: valid/ready handshake carrying mode, key and value.
// Depends on lfu_pkg for field widths.
`default_nettype none

interface lfu_req_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [KeyW-1:0]  key;
  logic signed [DataW-1:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lfu_rsp_if.sv @@
// Response channel: valid/ready handshake carrying hit, read_value and evicted.
// Depends on lfu_pkg for field widths.
`default_nettype none

interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [DataW-1:0] read_value;
  logic                    evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lfu_cache_lookup_insert.sv @@
// Top level of the LFU cache lookup/insert block: controller plus datapath.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_ctrl, lfu_dpath, lfu_ram.
//
//   channel  direction  handshake          payload
//   req_i    in         valid/ready        mode, key, value
//   rsp_o    out        valid/ready        hit, read_value, evicted
//   cfg      in         cfg_we_i           cfg_wdata_i = capacity_in_use
//
// A request passes through acceptance, one read per occupied entry (at most
// ENTRIES) through the single RAM read port, the compare of the last entry,
// and write-back, which loads the result register. Reset clears occupancy,
// the recency clock and the result valid flag at once; no clearing pass. A
// stalled result holds in its register; the next request is taken meanwhile
// and waits at write-back.
`default_nettype none

module lfu_cache_lookup_insert
  import lfu_pkg::*;
#(
  parameter int ENTRIES = DefEntries
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CapW-1:0] cfg_wdata_i,
  lfu_req_if.sink              req_i,
  lfu_rsp_if.source            rsp_o
);

  lfu_cmd_t    cmd;
  lfu_status_t status;
  logic [DataW-1:0] read_value;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfu_dpath #(
    .Entries(ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_mode_i       (req_i.mode),
    .req_key_i        (req_i.key),
    .req_value_i      (req_i.value),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_hit_o        (rsp_o.hit),
    .rsp_read_value_o (read_value),
    .rsp_evicted_o    (rsp_o.evicted),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  assign rsp_o.read_value = read_value;

endmodule

`default_nettype wire

@@ rtl/core/lfu_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lfu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lfu_ctrl.sv @@
// Sequencer for the LFU cache: accept, scan, commit.
// Depends on lfu_pkg for the state enum and the command/status structs.
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire lfu_status_t status_i,
  output lfu_cmd_t         cmd_o
);

  lfu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        // hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> $past(state_q == StScan) || $past(state_q == StCommit))
    else $error("commit without a preceding scan");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == StScan)
    else $error("start did not enter scan");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.scan, cmd_o.commit}))
    else $error("more than one command at once");

endmodule

`default_nettype wire

@@ rtl/core/lfu_dpath.sv @@
// Datapath for the LFU cache: request and config registers, entry scan,
// victim search, write-back and result register. Depends on lfu_pkg, lfu_ram.
`default_nettype none

module lfu_dpath
  import lfu_pkg::*;
#(
  parameter int Entries = DefEntries
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CapW-1:0]         cfg_wdata_i,
  input  wire logic                    req_mode_i,
  input  wire logic [KeyW-1:0]         req_key_i,
  input  wire logic [DataW-1:0]        req_value_i,
  input  wire logic                    rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic                         rsp_hit_o,
  output logic [DataW-1:0]             rsp_read_value_o,
  output logic                         rsp_evicted_o,
  input  wire lfu_cmd_t                cmd_i,
  output lfu_status_t                  status_o
);

  localparam int AW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CW   = $clog2(Entries + 1);
  localparam int CmpW = ((CW > CapW) ? CW : CapW) + 1;
  localparam logic [CmpW-1:0] EntriesCmp = CmpW'(Entries);

  // configuration and captured request
  logic [CapW-1:0]  cap_q;
  logic             mode_q;
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] value_q;

  // occupancy: entries never go invalid, so slots 0..fill-1 are the valid ones
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     rd_cnt_q;
  logic [StampW-1:0] clock_q;

  logic              rd_en;
  logic              cmp_en_q;
  logic [AW-1:0]     cmp_idx_q;
  logic [WordW-1:0]  rdata;

  logic              match_found_q;
  logic [AW-1:0]     match_idx_q;
  logic [DataW-1:0]  match_data_q;
  logic [CountW-1:0] match_cnt_q;

  logic              vic_found_q;
  logic [AW-1:0]     vic_idx_q;
  logic [CountW-1:0] vic_cnt_q;
  logic [StampW-1:0] vic_age_q;

  logic              out_valid_q;
  logic              out_hit_q;
  logic [DataW-1:0]  out_value_q;
  logic              out_evicted_q;

  // scan read
  assign rd_en = cmd_i.scan && (rd_cnt_q != fill_q);
  assign status_o.scan_done = (rd_cnt_q == fill_q);
  assign status_o.out_free  = !out_valid_q || rsp_ready_i;

  // entry fields from the returned word
  logic [KeyW-1:0]   e_key;
  logic [DataW-1:0]  e_data;
  logic [CountW-1:0] e_cnt;
  logic [StampW-1:0] e_rec;
  logic [StampW-1:0] e_age;
  logic              e_match, e_better;

  assign {e_key, e_data, e_cnt, e_rec} = rdata;
  assign e_age    = clock_q - e_rec;
  assign e_match  = !match_found_q && (e_key == key_q);
  assign e_better = !vic_found_q || (e_cnt < vic_cnt_q) ||
                    ((e_cnt == vic_cnt_q) && (e_age > vic_age_q));

  // write-back decision
  logic [CmpW-1:0]   cap_eff;
  logic              do_write, evict;
  logic [AW-1:0]     waddr;
  logic [WordW-1:0]  wdata;
  logic [StampW-1:0] stamp_next;
  logic [CountW-1:0] cnt_inc;
  logic [DataW-1:0]  res_value;

  assign cap_eff    = (CmpW'(cap_q) > EntriesCmp) ? EntriesCmp : CmpW'(cap_q);
  assign stamp_next = clock_q + StampW'(1);
  assign cnt_inc    = (match_cnt_q == CountMax) ? match_cnt_q : match_cnt_q + CountW'(1);

  always_comb begin
    do_write  = 1'b0;
    evict     = 1'b0;
    waddr     = match_idx_q;
    wdata     = {key_q, value_q, CountNew, stamp_next};
    fill_d    = fill_q;
    res_value = MissValue;
    if (match_found_q) begin
      do_write = 1'b1;
      if (mode_q == ModePut) begin
        wdata = {key_q, value_q, cnt_inc, stamp_next};
      end else begin
        wdata     = {key_q, match_data_q, cnt_inc, stamp_next};
        res_value = match_data_q;
      end
    end else if ((mode_q == ModePut) && (cap_q != '0)) begin
      if (CmpW'(fill_q) >= cap_eff) begin
        do_write = 1'b1;
        evict    = 1'b1;
        waddr    = vic_idx_q;
      end else if (CmpW'(fill_q) < EntriesCmp) begin
        do_write = 1'b1;
        waddr    = fill_q[AW-1:0];
        fill_d   = fill_q + CW'(1);
      end
    end
  end

  lfu_ram #(
    .Width(WordW),
    .Depth(Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && do_write),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= CapReset;
      fill_q        <= '0;
      rd_cnt_q      <= '0;
      clock_q       <= '0;
      cmp_en_q      <= 1'b0;
      match_found_q <= 1'b0;
      vic_found_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cmp_en_q <= rd_en;
      if (cmd_i.start) begin
        rd_cnt_q      <= '0;
        match_found_q <= 1'b0;
        vic_found_q   <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        if (cmp_en_q) begin
          if (e_match) begin
            match_found_q <= 1'b1;
          end
          vic_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
        if (do_write) begin
          clock_q <= stamp_next;
        end
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_cnt_q[AW-1:0];
    if (cmd_i.start) begin
      mode_q  <= req_mode_i;
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end
    if (cmp_en_q && e_match) begin
      match_idx_q  <= cmp_idx_q;
      match_data_q <= e_data;
      match_cnt_q  <= e_cnt;
    end
    if (cmp_en_q && e_better) begin
      vic_idx_q <= cmp_idx_q;
      vic_cnt_q <= e_cnt;
      vic_age_q <= e_age;
    end
    if (cmd_i.commit) begin
      out_hit_q     <= match_found_q;
      out_value_q   <= res_value;
      out_evicted_q <= evict;
    end
  end

  assign rsp_valid_o      = out_valid_q;
  assign rsp_hit_o        = out_hit_q;
  assign rsp_read_value_o = out_value_q;
  assign rsp_evicted_o    = out_evicted_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(fill_q) <= EntriesCmp)
    else $error("occupancy above entry count");

  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && evict) |-> vic_found_q)
    else $error("eviction without a victim");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_cnt_q < fill_q))
    else $error("scan read beyond occupied entries");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_ready_i) |-> !cmd_i.commit)
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire
